### sv/afla_pkg.sv
// ----------------------------------------------------------------------------
// afla_pkg: shared types, constants and helpers
// Beat formats, the control word of the sequencer and its microcode table,
// and the alignment helpers that the datapath uses.
// ----------------------------------------------------------------------------
package afla_pkg;

  localparam int MaxEntries = 32;
  localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW = $clog2(MaxEntries + 1);
  localparam int NumW = 5;
  localparam int OffW = 16;
  localparam int TotW = 17;
  localparam int AlnW = 8;
  localparam int SizeW = 8;
  localparam int LogW = 3;

  localparam logic [LogW-1:0] CapLog = 3'd7;
  localparam logic [TotW-1:0] OffsetLimit = 17'h0FFFF;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdCompute = 1'b1;
  localparam logic StatusOk = 1'b0;
  localparam logic StatusOverflow = 1'b1;

  typedef struct packed {
    logic              command;
    logic [SizeW-1:0]  entry_size;
    logic [AlnW-1:0]   entry_alignment;
    logic              entry_enabled;
    logic [OffW-1:0]   base_offset;
    logic [AlnW-1:0]   base_alignment;
  } item_t;

  typedef struct packed {
    logic [NumW-1:0]   entry_number;
    logic [OffW-1:0]   entry_offset;
    logic              entry_placed;
    logic [TotW-1:0]   total_size;
    logic [AlnW-1:0]   max_alignment;
    logic              status;
    logic              last;
  } result_t;

  typedef enum logic [1:0] {
    StWait,
    StScan,
    StEmit,
    StSum
  } step_t;

  typedef enum logic [1:0] {
    CondCompute,
    CondScanDone,
    CondEntryDone,
    CondSumOut
  } cond_t;

  // One microcode word: datapath strobes plus the jump condition and target.
  // A step whose condition is false repeats.
  typedef struct packed {
    logic  in_ready;
    logic  scan;
    logic  emit_entry;
    logic  emit_sum;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic compute;
    logic scan_done;
    logic entries_done;
    logic sum_out;
  } flags_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w = '{in_ready: 1'b0, scan: 1'b0, emit_entry: 1'b0, emit_sum: 1'b0,
          cond: CondCompute, target: StWait};
    case (step)
      StWait: begin
        w.in_ready = 1'b1;
        w.cond = CondCompute;
        w.target = StScan;
      end
      StScan: begin
        w.scan = 1'b1;
        w.cond = CondScanDone;
        w.target = StEmit;
      end
      StEmit: begin
        w.emit_entry = 1'b1;
        w.cond = CondEntryDone;
        w.target = StSum;
      end
      StSum: begin
        w.emit_sum = 1'b1;
        w.cond = CondSumOut;
        w.target = StWait;
      end
      default: begin
        w.target = StWait;
      end
    endcase
    return w;
  endfunction

  // Highest set bit among bits 7..1; zero when none is set.
  function automatic logic [LogW-1:0] high_log(input logic [AlnW-1:0] v);
    logic [LogW-1:0] l;
    l = '0;
    for (int i = 1; i < AlnW; i++) begin
      if (v[i]) begin
        l = LogW'(i);
      end
    end
    return l;
  endfunction

  // Lowest set bit of the base offset, capped at the largest alignment.
  function automatic logic [LogW-1:0] low_log(input logic [OffW-1:0] v);
    logic [LogW-1:0] l;
    l = CapLog;
    for (int i = 6; i >= 0; i--) begin
      if (v[i]) begin
        l = LogW'(i);
      end
    end
    return l;
  endfunction

  function automatic logic [TotW-1:0] round_up(input logic [TotW-1:0] v,
                                               input logic [LogW-1:0] lg);
    logic [TotW-1:0] m;
    m = (TotW'(1) << lg) - TotW'(1);
    return (v + m) & ~m;
  endfunction

endpackage

### sv/afla_seq.sv
// ----------------------------------------------------------------------------
// afla_seq: microcode sequencer
// Holds the step counter, reads the control word of the current step from
// the microcode table and jumps when the selected condition is met.
// ----------------------------------------------------------------------------
module afla_seq (
  input  logic            clk,
  input  logic            rst,
  input  afla_pkg::flags_t flags,
  output afla_pkg::ctrl_t  ctrl
);
  import afla_pkg::*;

  step_t step;
  step_t step_next;
  logic  jump;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= StWait;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    ctrl = ucode(step);
    case (ctrl.cond)
      CondCompute:   jump = flags.compute;
      CondScanDone:  jump = flags.scan_done;
      CondEntryDone: jump = flags.entries_done;
      CondSumOut:    jump = flags.sum_out;
      default:       jump = 1'b0;
    endcase
    step_next = jump ? ctrl.target : step;
  end

endmodule

### sv/afla_dp.sv
// ----------------------------------------------------------------------------
// afla_dp: entry table and layout datapath
// Stores loaded entries, walks them one per cycle under control of the
// sequencer to place them, and drives the result output register.
// ----------------------------------------------------------------------------
module afla_dp (
  input  logic              clk,
  input  logic              rst,
  input  afla_pkg::ctrl_t   ctrl,
  input  logic              item_acc,
  input  afla_pkg::item_t   item,
  input  logic              result_ready,
  output logic              result_valid,
  output afla_pkg::result_t result,
  output afla_pkg::flags_t  flags
);
  import afla_pkg::*;

  // Entry table; every entry below the fill count has been written.
  logic [SizeW-1:0]      size_mem   [MaxEntries];
  logic [LogW-1:0]       log_mem    [MaxEntries];
  logic                  en_mem     [MaxEntries];
  logic [OffW-1:0]       offset_mem [MaxEntries];
  logic [MaxEntries-1:0] placed;

  logic [CntW-1:0] count;
  logic            fresh;
  logic [IdxW-1:0] idx;
  logic [LogW-1:0] lg;
  logic            pass;

  logic [TotW-1:0] offset;
  logic [LogW-1:0] cur_log;
  logic [LogW-1:0] max_log;
  logic            overflow;

  logic            load_acc;
  logic            comp_acc;
  logic            room;
  logic [IdxW-1:0] wr_idx;
  logic            empty;
  logic            idx_is_last;
  logic            cand;
  logic            tried;
  logic [TotW-1:0] off_pad;
  logic [TotW-1:0] size_pad;
  logic            ovf_now;
  logic            place;
  logic            out_free;
  logic            emit_entry;
  logic            emit_sum;
  result_t         entry_beat;
  result_t         sum_beat;

  always_comb begin
    load_acc    = item_acc && (item.command == CmdLoad);
    comp_acc    = item_acc && (item.command == CmdCompute);
    room        = fresh || (count < CntW'(MaxEntries));
    wr_idx      = fresh ? '0 : count[IdxW-1:0];
    empty       = (count == '0);
    idx_is_last = (CntW'(idx) + CntW'(1)) == count;

    // The first pass takes an entry only where no padding is needed; the
    // second pass pads the running offset up to the entry's alignment.
    cand     = (log_mem[idx] == lg) && en_mem[idx] && !placed[idx];
    tried    = cand && (pass || (cur_log >= lg));
    off_pad  = pass ? round_up(offset, lg) : offset;
    size_pad = round_up(TotW'(size_mem[idx]), lg);
    ovf_now  = ctrl.scan && !empty && tried && (off_pad > OffsetLimit);
    place    = ctrl.scan && !empty && tried && !(off_pad > OffsetLimit);

    out_free   = !result_valid || result_ready;
    emit_entry = ctrl.emit_entry && !empty && out_free;
    emit_sum   = ctrl.emit_sum && out_free;

    flags.compute      = comp_acc;
    flags.scan_done    = empty || ovf_now || (idx_is_last && (lg == '0) && pass);
    flags.entries_done = empty || (out_free && idx_is_last);
    flags.sum_out      = out_free;

    entry_beat = '0;
    entry_beat.entry_number = NumW'(idx);
    entry_beat.entry_placed = placed[idx];
    entry_beat.entry_offset = placed[idx] ? offset_mem[idx] : '0;

    sum_beat = '0;
    sum_beat.total_size    = overflow ? '0 : round_up(offset, max_log);
    sum_beat.max_alignment = AlnW'(1) << max_log;
    sum_beat.status        = overflow ? StatusOverflow : StatusOk;
    sum_beat.last          = 1'b1;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      fresh        <= 1'b1;
      idx          <= '0;
      lg           <= CapLog;
      pass         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (load_acc) begin
        fresh <= 1'b0;
        if (room) begin
          count <= fresh ? CntW'(1) : count + CntW'(1);
        end
      end
      if (comp_acc) begin
        fresh <= 1'b1;
        idx   <= '0;
        lg    <= CapLog;
        pass  <= 1'b0;
      end
      if (ctrl.scan) begin
        if (ovf_now || empty) begin
          idx <= '0;
        end else if (idx_is_last) begin
          idx <= '0;
          if (lg == '0) begin
            pass <= 1'b1;
            lg   <= CapLog;
          end else begin
            lg <= lg - LogW'(1);
          end
        end else begin
          idx <= idx + IdxW'(1);
        end
      end
      if (emit_entry) begin
        idx <= idx_is_last ? '0 : idx + IdxW'(1);
      end
      if (emit_entry || emit_sum) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Layout accumulators, table contents and the output beat.
  always_ff @(posedge clk) begin
    if (comp_acc) begin
      offset   <= TotW'(item.base_offset);
      max_log  <= high_log(item.base_alignment);
      cur_log  <= low_log(item.base_offset);
      overflow <= 1'b0;
    end
    if (ovf_now) begin
      overflow <= 1'b1;
    end
    if (place) begin
      offset  <= off_pad + size_pad;
      cur_log <= lg;
      if (max_log < lg) begin
        max_log <= lg;
      end
      offset_mem[idx] <= off_pad[OffW-1:0];
      placed[idx]     <= 1'b1;
    end
    if (load_acc && room) begin
      size_mem[wr_idx]   <= item.entry_size;
      log_mem[wr_idx]    <= high_log(item.entry_alignment);
      en_mem[wr_idx]     <= item.entry_enabled;
      offset_mem[wr_idx] <= '0;
      placed[wr_idx]     <= 1'b0;
    end
    if (emit_entry) begin
      result <= entry_beat;
    end else if (emit_sum) begin
      result <= sum_beat;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MaxEntries))
    else $error("entry count above table depth");

  a_compute_init: assert property (@(posedge clk) disable iff (rst)
    comp_acc |=> fresh && !overflow && !pass && (lg == CapLog) && (idx == '0))
    else $error("compute did not restart the layout walk");

  a_entry_beat_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |->
      (result.total_size == '0) && (result.max_alignment == '0) &&
      (result.status == StatusOk))
    else $error("entry beat carries summary fields");

endmodule

### sv/aligned_field_layout_assigner_unit.sv
// ----------------------------------------------------------------------------
// aligned_field_layout_assigner_unit: top level
// Packs aligned entries into a layout, reporting each entry's offset and a
// summary with total size, largest alignment and overflow status.
// ----------------------------------------------------------------------------
// A load beat is taken while the sequencer waits and the block stays ready for
// the next item. A compute beat is followed by a placement walk that visits one
// table entry per cycle through the entry table's single read port: two passes
// over eight alignment levels, each level visiting all N loaded entries (an
// empty table or an overflow ends the walk early). The block then sends N entry
// beats and one summary beat, one per cycle while result_ready stays high, and
// takes the next item once the summary beat is in the output register.
module aligned_field_layout_assigner_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  afla_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output afla_pkg::result_t result
);
  import afla_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;
  logic   item_acc;

  assign item_ready = ctrl.in_ready;
  assign item_acc   = item_valid && ctrl.in_ready;

  afla_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  afla_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .item_acc     (item_acc),
    .item         (item),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result),
    .flags        (flags)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for aligned_field_layout_assigner_unit
// Loads entry tables and runs layout computes through the item channel, works
// out the offsets, total size and status of each compute on its own, and
// checks every result beat against them while both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  import afla_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int MaxPrinted = 30;
  localparam int TopLog = 7;
  localparam int unsigned OffsetMax = 32'hFFFF;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  int send_idle_pct;
  int recv_idle_pct;
  int stall_request;
  int stall_left;
  int error_count;
  int quiet_cycles;
  int beat_count;

  // Expected result beats, oldest first.
  result_t expected_placements[$];

  // Shadow copy of the entry table.
  bit [7:0]    size_mem[MaxEntries];
  bit [2:0]    log_mem[MaxEntries];
  bit          enable_mem[MaxEntries];
  bit          placed_mem[MaxEntries];
  bit [15:0]   offset_mem[MaxEntries];
  int unsigned entry_count;
  bit          new_table_pending;

  aligned_field_layout_assigner_unit u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Alignment values that are not a power of two count as their highest set bit.
  function automatic int unsigned top_bit_log(input bit [7:0] v);
    int unsigned l;
    l = 0;
    for (int i = 1; i <= TopLog; i++) begin
      if (v[i]) begin
        l = i;
      end
    end
    return l;
  endfunction

  function automatic int unsigned align_to(input int unsigned v, input int unsigned lg);
    int unsigned m;
    m = (32'd1 << lg) - 1;
    return (v + m) & ~m;
  endfunction

  function automatic void predict_layout(input item_t b);
    int unsigned offset;
    int unsigned max_log;
    int unsigned cur_log;
    int unsigned n;
    bit          overflow;
    result_t     r;
    if (b.command == CmdLoad) begin
      if (new_table_pending) begin
        entry_count = 0;
        new_table_pending = 1'b0;
      end
      if (entry_count < MaxEntries) begin
        size_mem[entry_count] = b.entry_size;
        log_mem[entry_count] = 3'(top_bit_log(b.entry_alignment));
        enable_mem[entry_count] = b.entry_enabled;
        placed_mem[entry_count] = 1'b0;
        offset_mem[entry_count] = '0;
        entry_count++;
      end
      return;
    end
    new_table_pending = 1'b1;
    offset = b.base_offset;
    max_log = top_bit_log(b.base_alignment);
    cur_log = TopLog;
    if (offset != 0) begin
      cur_log = 0;
      while (cur_log < TopLog && offset[cur_log] == 1'b0) begin
        cur_log++;
      end
    end
    n = entry_count;
    overflow = 1'b0;
    // The first pass only takes entries that fit without padding.
    for (int pass = 0; pass < 2 && !overflow; pass++) begin
      for (int lg = TopLog; lg >= 0 && !overflow; lg--) begin
        for (int i = 0; i < n; i++) begin
          if (log_mem[i] != lg || !enable_mem[i] || placed_mem[i]) begin
            continue;
          end
          if (pass == 1) begin
            offset = align_to(offset, lg);
          end else if (cur_log < lg) begin
            continue;
          end
          if (offset > OffsetMax) begin
            overflow = 1'b1;
            break;
          end
          if (max_log < lg) begin
            max_log = lg;
          end
          offset_mem[i] = offset[15:0];
          placed_mem[i] = 1'b1;
          offset += align_to(size_mem[i], lg);
          cur_log = lg;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      r = '0;
      r.entry_number = 5'(k);
      r.entry_offset = placed_mem[k] ? offset_mem[k] : 16'd0;
      r.entry_placed = placed_mem[k];
      expected_placements.push_back(r);
    end
    r = '0;
    r.total_size = overflow ? 17'd0 : 17'(align_to(offset, max_log));
    r.max_alignment = 8'(32'd1 << max_log);
    r.status = overflow ? StatusOverflow : StatusOk;
    r.last = 1'b1;
    expected_placements.push_back(r);
  endfunction

  function automatic item_t random_beat();
    item_t b;
    b.command = 1'($urandom_range(0, 1));
    b.entry_size = 8'($urandom);
    b.entry_alignment = 8'($urandom);
    b.entry_enabled = 1'($urandom_range(0, 1));
    b.base_offset = 16'($urandom);
    b.base_alignment = 8'($urandom);
    return b;
  endfunction

  function automatic item_t load_beat(input bit [7:0] size, input bit [7:0] align,
                                      input bit enabled);
    item_t b;
    b = random_beat();
    b.command = CmdLoad;
    b.entry_size = size;
    b.entry_alignment = align;
    b.entry_enabled = enabled;
    return b;
  endfunction

  function automatic item_t compute_beat(input bit [15:0] offset, input bit [7:0] align);
    item_t b;
    b = random_beat();
    b.command = CmdCompute;
    b.base_offset = offset;
    b.base_alignment = align;
    return b;
  endfunction

  function automatic bit [7:0] random_alignment();
    if ($urandom_range(0, 4) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return 8'(32'd1 << $urandom_range(0, 7));
  endfunction

  function automatic bit [15:0] random_base_offset();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1, 2: return 16'($urandom_range(0, 65535));
      // Close to the top of the range, so that larger tables overflow.
      3: return 16'hF000 | 16'($urandom_range(0, 16'h0FFF));
      default: return 16'($urandom_range(0, 255) << $urandom_range(0, 8));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MaxPrinted) begin
      $display("%0t: result beat %0d: %s", $realtime, beat_count, msg);
    end
  endtask

  task automatic check_beat(input result_t got);
    result_t want;
    if (expected_placements.size() == 0) begin
      report_mismatch($sformatf("unexpected beat %p", got));
      return;
    end
    want = expected_placements.pop_front();
    if (got.entry_number !== want.entry_number)
      report_mismatch($sformatf("entry_number %0d, expected %0d",
                                got.entry_number, want.entry_number));
    if (got.entry_offset !== want.entry_offset)
      report_mismatch($sformatf("entry_offset %0d, expected %0d",
                                got.entry_offset, want.entry_offset));
    if (got.entry_placed !== want.entry_placed)
      report_mismatch($sformatf("entry_placed %0d, expected %0d",
                                got.entry_placed, want.entry_placed));
    if (got.total_size !== want.total_size)
      report_mismatch($sformatf("total_size %0d, expected %0d",
                                got.total_size, want.total_size));
    if (got.max_alignment !== want.max_alignment)
      report_mismatch($sformatf("max_alignment %0d, expected %0d",
                                got.max_alignment, want.max_alignment));
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      check_beat(result);
      beat_count++;
    end
  end

  // A requested hold-off keeps ready low until the requested stall has run down.
  always @(negedge clk) begin
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no beat accepted for %0d cycles", $realtime, WatchdogLimit);
        $display("[aligned_field_layout_assigner_unit] ERROR");
        $finish;
      end
    end
  end

  // Returns right after the edge that accepts the beat; valid stays high
  // until the next call or the end of the run lowers it.
  task automatic send_item(input item_t b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= b;
    @(posedge clk);
    while (!item_ready) begin
      @(posedge clk);
    end
    predict_layout(b);
  endtask

  task automatic test_empty_table();
    send_item(compute_beat(16'h0040, 8'h01));
  endtask

  task automatic test_extremes();
    send_item(load_beat(8'd255, 8'd128, 1'b1));
    send_item(load_beat(8'd0, 8'd1, 1'b1));
    send_item(load_beat(8'd37, 8'd0, 1'b1));
    send_item(load_beat(8'd200, 8'd255, 1'b1));
    send_item(load_beat(8'd9, 8'd3, 1'b1));
    send_item(load_beat(8'd100, 8'd64, 1'b0));
    send_item(load_beat(8'd1, 8'd2, 1'b1));
    send_item(compute_beat(16'd0, 8'd0));
    // Nothing new to place: the held offsets come back unchanged.
    send_item(compute_beat(16'h0004, 8'h80));
    send_item(load_beat(8'd255, 8'd1, 1'b1));
    send_item(load_beat(8'd255, 8'd1, 1'b1));
    send_item(compute_beat(16'hFFFF, 8'hFF));
  endtask

  task automatic test_overflow();
    send_item(load_beat(8'd255, 8'd128, 1'b1));
    send_item(load_beat(8'd255, 8'd128, 1'b1));
    send_item(load_beat(8'd10, 8'd4, 1'b1));
    send_item(compute_beat(16'hFF00, 8'h01));
    // Here the overflow is only found in the second pass.
    send_item(load_beat(8'd16, 8'd1, 1'b1));
    send_item(load_beat(8'd8, 8'd64, 1'b1));
    send_item(compute_beat(16'hFFF1, 8'h01));
  endtask

  task automatic test_table_full();
    repeat (MaxEntries + 2) begin
      send_item(load_beat(8'($urandom_range(0, 40)), random_alignment(), 1'b1));
    end
    send_item(compute_beat(16'd0, random_alignment()));
  endtask

  task automatic test_random(input int beats);
    int sent;
    int k;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(0, 99) < 15) begin
        send_item(random_beat());
        sent++;
      end else begin
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MaxEntries) : $urandom_range(0, 8);
        repeat (k) begin
          send_item(load_beat(8'($urandom), random_alignment(), $urandom_range(0, 99) < 85));
        end
        send_item(compute_beat(random_base_offset(), random_alignment()));
        sent += k + 1;
        if ($urandom_range(0, 9) == 0) begin
          send_item(compute_beat(random_base_offset(), random_alignment()));
          sent++;
        end
      end
    end
  endtask

  // The receiver stops for a long stretch while computes keep coming, so the
  // result side fills up and the item channel has to stall.
  task automatic test_backpressure();
    stall_request = 300;
    repeat (3) begin
      repeat (4) begin
        send_item(load_beat(8'($urandom), random_alignment(), 1'b1));
      end
      send_item(compute_beat(random_base_offset(), random_alignment()));
    end
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 62;
    stall_request = 0;
    stall_left = 0;
    error_count = 0;
    quiet_cycles = 0;
    beat_count = 0;
    entry_count = 0;
    new_table_pending = 1'b1;
    for (int i = 0; i < MaxEntries; i++) begin
      size_mem[i] = '0;
      log_mem[i] = '0;
      enable_mem[i] = 1'b0;
      placed_mem[i] = 1'b0;
      offset_mem[i] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_extremes();
    test_overflow();
    test_table_full();
    test_random(85);
    send_idle_pct = 62;
    recv_idle_pct = 18;
    test_random(85);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(70);

    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_placements.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("[aligned_field_layout_assigner_unit] OK");
    end else begin
      $display("[aligned_field_layout_assigner_unit] ERROR");
    end
    $finish;
  end

endmodule

### files.f
sv/afla_pkg.sv
sv/afla_seq.sv
sv/afla_dp.sv
sv/aligned_field_layout_assigner_unit.sv
tb/tb.sv
